>>> design/rrj_pkg.sv
// shared types, constants and tables for the range residual / jacobian pipeline
// no dependencies; every design module imports it
package rrj_pkg;

    // pipeline depths of the cell chains
    localparam int CORDIC_N = 17;
    localparam int SQRT_N   = 36;
    localparam int DIV_N    = 35;
    // stage index of the output register (input reg, cordic, 5 math stages, sqrt, div)
    localparam int LAT      = 1 + CORDIC_N + 5 + SQRT_N + DIV_N;

    // heading fold limits, q.16 radians
    localparam logic signed [19:0] HALF_PI = 20'sd102944;
    localparam logic signed [19:0] PI_Q16  = 20'sd205887;
    // cordic start vector, q.30, gain already folded in
    localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

    // datapath widths
    localparam int CSW  = 33;   // cordic x/y, q.30
    localparam int ANW  = 20;   // cordic residual angle
    localparam int RXW  = 34;   // rotated tag offset
    localparam int ALW  = 36;   // difference vector, signed
    localparam int AMW  = 35;   // difference vector magnitude
    localparam int RADW = 72;   // sqrt radicand, padded to even width
    localparam int RTW  = 36;   // sqrt root = distance
    localparam int REMW = 39;   // sqrt partial remainder
    localparam int NUMW = 72;   // divider numerator / remainder
    localparam int QW   = 35;   // divider quotient

    // config register indexes
    localparam logic [1:0] REG_POSE_X  = 2'd0;
    localparam logic [1:0] REG_POSE_Y  = 2'd1;
    localparam logic [1:0] REG_HEADING = 2'd2;

    typedef logic signed [CSW-1:0] t_cs;
    typedef logic signed [ANW-1:0] t_ang;

    // request fields carried alongside the cordic chain
    typedef struct packed {
        logic signed [31:0] xt;
        logic signed [31:0] yt;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic [30:0]        mr;
    } t_geo;

    // side data carried alongside the sqrt chain
    typedef struct packed {
        logic            sa;
        logic            sg;
        logic            sn;
        logic [AMW-1:0]  am;
        logic [AMW-1:0]  gm;
        logic [NUMW-1:0] nm;
        logic [30:0]     mr;
    } t_side1;

    // side data carried alongside the divider chains
    typedef struct packed {
        logic               sa;
        logic               sg;
        logic               sn;
        logic               deg;
        logic signed [31:0] res;
    } t_side2;

    // arctangent of 2^-i, q.16
    function automatic t_ang f_atan(input logic [4:0] i);
        t_ang a;
        case (i)
            5'd0:  a = 20'sd51472;
            5'd1:  a = 20'sd30385;
            5'd2:  a = 20'sd16055;
            5'd3:  a = 20'sd8150;
            5'd4:  a = 20'sd4091;
            5'd5:  a = 20'sd2047;
            5'd6:  a = 20'sd1024;
            5'd7:  a = 20'sd512;
            5'd8:  a = 20'sd256;
            5'd9:  a = 20'sd128;
            5'd10: a = 20'sd64;
            5'd11: a = 20'sd32;
            5'd12: a = 20'sd16;
            5'd13: a = 20'sd8;
            5'd14: a = 20'sd4;
            5'd15: a = 20'sd2;
            5'd16: a = 20'sd1;
            default: a = 20'sd0;
        endcase
        return a;
    endfunction

endpackage

>>> design/range_residual_jacobian_2d_top.sv
// Range residual and jacobian row for 2D pose least squares: one request is taken
// per clock while busy is low, and its result strobes o_valid at the end of the pipeline; the receiver
// cannot stall, so results must be captured on the strobe. The depth is set by the
// 17-cell cordic chain, five multiply/add stages, the 36-cell square root chain and
// the 35-cell divider chains. busy is high only during reset and the cycle after.
// Pose registers are written through i_cfg_*; write them only with no request in flight.
// depends on rrj_pkg, rrj_cordic_cell, rrj_sqrt_cell, rrj_div_cell
module range_residual_jacobian_2d_top import rrj_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_tag_offset_x,
    input  logic signed [31:0] i_tag_offset_y,
    input  logic signed [31:0] i_anchor_x,
    input  logic signed [31:0] i_anchor_y,
    input  logic [30:0]        i_measured_range,
    output logic               o_valid,
    output logic signed [31:0] o_range_residual,
    output logic signed [17:0] o_jac_x,
    output logic signed [17:0] o_jac_y,
    output logic signed [31:0] o_jac_heading,
    output logic               o_degenerate
);
    // pose registers
    logic signed [31:0] r_pose_x, r_pose_y;
    logic signed [18:0] r_pose_h;
    logic               r_busy;
    logic [LAT:0]       r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose_x <= '0;
            r_pose_y <= '0;
            r_pose_h <= '0;
            r_busy   <= 1'b1;
            r_vld    <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[LAT-1:0], start & ~r_busy};
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_POSE_X:  r_pose_x <= i_cfg_data;
                    REG_POSE_Y:  r_pose_y <= i_cfg_data;
                    REG_HEADING: r_pose_h <= i_cfg_data[18:0];
                    default: ;
                endcase
            end
        end
    end

    assign busy = r_busy;

    // input stage: capture request and fold heading into half circle
    t_ang w_h, n_z0, r_z0;
    logic n_flip0, r_flip0;
    t_geo r_geo [0:CORDIC_N];

    always_comb begin
        w_h     = t_ang'(r_pose_h);
        n_z0    = w_h;
        n_flip0 = 1'b0;
        if (w_h > HALF_PI) begin
            n_z0    = w_h - PI_Q16;
            n_flip0 = 1'b1;
        end else if (w_h < -HALF_PI) begin
            n_z0    = w_h + PI_Q16;
            n_flip0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z0      <= n_z0;
        r_flip0   <= n_flip0;
        r_geo[0]  <= '{xt: i_tag_offset_x, yt: i_tag_offset_y, ax: i_anchor_x,
                       ay: i_anchor_y, mr: i_measured_range};
        for (int k = 1; k <= CORDIC_N; k++) begin
            r_geo[k] <= r_geo[k-1];
        end
    end

    // cordic chain
    t_cs  w_cx [0:CORDIC_N];
    t_cs  w_cy [0:CORDIC_N];
    t_ang w_cz [0:CORDIC_N];
    logic w_cf [0:CORDIC_N];

    assign w_cx[0] = CORDIC_X0;
    assign w_cy[0] = '0;
    assign w_cz[0] = r_z0;
    assign w_cf[0] = r_flip0;

    for (genvar g = 0; g < CORDIC_N; g++) begin : g_cordic
        rrj_cordic_cell u_cell (
            .i_clk  (i_clk),
            .i_step (5'(g)),
            .i_x    (w_cx[g]),
            .i_y    (w_cy[g]),
            .i_z    (w_cz[g]),
            .i_flip (w_cf[g]),
            .o_x    (w_cx[g+1]),
            .o_y    (w_cy[g+1]),
            .o_z    (w_cz[g+1]),
            .o_flip (w_cf[g+1])
        );
    end

    // rotation products
    t_cs                w_c, w_s;
    logic signed [64:0] r_pxc, r_pys, r_pxs, r_pyc;
    logic signed [31:0] r_m_ax, r_m_ay;
    logic [30:0]        r_m_mr;

    assign w_c = w_cf[CORDIC_N] ? -w_cx[CORDIC_N] : w_cx[CORDIC_N];
    assign w_s = w_cf[CORDIC_N] ? -w_cy[CORDIC_N] : w_cy[CORDIC_N];

    always_ff @(posedge i_clk) begin
        r_pxc  <= r_geo[CORDIC_N].xt * w_c;
        r_pys  <= r_geo[CORDIC_N].yt * w_s;
        r_pxs  <= r_geo[CORDIC_N].xt * w_s;
        r_pyc  <= r_geo[CORDIC_N].yt * w_c;
        r_m_ax <= r_geo[CORDIC_N].ax;
        r_m_ay <= r_geo[CORDIC_N].ay;
        r_m_mr <= r_geo[CORDIC_N].mr;
    end

    // rounded rotated offset
    logic signed [65:0]    n_sx, n_sy;
    logic signed [RXW-1:0] r_rx, r_ry;
    logic signed [31:0]    r_r_ax, r_r_ay;
    logic [30:0]           r_r_mr;

    assign n_sx = 66'(r_pxc) - 66'(r_pys) + 66'sd536870912;
    assign n_sy = 66'(r_pxs) + 66'(r_pyc) + 66'sd536870912;

    always_ff @(posedge i_clk) begin
        r_rx   <= n_sx[30 +: RXW];
        r_ry   <= n_sy[30 +: RXW];
        r_r_ax <= r_m_ax;
        r_r_ay <= r_m_ay;
        r_r_mr <= r_m_mr;
    end

    // difference vector
    logic signed [ALW-1:0] r_al, r_ga;
    logic signed [RXW-1:0] r_g_rx, r_g_ry;
    logic [30:0]           r_g_mr;

    always_ff @(posedge i_clk) begin
        r_al   <= ALW'(r_pose_x) + ALW'(r_rx) - ALW'(r_r_ax);
        r_ga   <= ALW'(r_pose_y) + ALW'(r_ry) - ALW'(r_r_ay);
        r_g_rx <= r_rx;
        r_g_ry <= r_ry;
        r_g_mr <= r_r_mr;
    end

    // squares and cross products
    logic [AMW-1:0]     n_am, n_gm, r_am, r_gm;
    logic [2*AMW-1:0]   r_sqa, r_sqg;
    logic signed [69:0] r_pg, r_pa;
    logic               r_sa, r_sg;
    logic [30:0]        r_q_mr;

    assign n_am = r_al[ALW-1] ? AMW'(-r_al) : AMW'(r_al);
    assign n_gm = r_ga[ALW-1] ? AMW'(-r_ga) : AMW'(r_ga);

    always_ff @(posedge i_clk) begin
        r_sqa  <= n_am * n_am;
        r_sqg  <= n_gm * n_gm;
        r_pg   <= r_ga * r_g_rx;
        r_pa   <= r_al * r_g_ry;
        r_am   <= n_am;
        r_gm   <= n_gm;
        r_sa   <= r_al[ALW-1];
        r_sg   <= r_ga[ALW-1];
        r_q_mr <= r_g_mr;
    end

    // radicand and heading numerator magnitude
    logic signed [70:0] n_nv;
    logic [RADW-1:0]    r_ss;
    t_side1             r_side1 [0:SQRT_N];

    assign n_nv = 71'(r_pg) - 71'(r_pa);

    always_ff @(posedge i_clk) begin
        r_ss       <= RADW'(r_sqa) + RADW'(r_sqg);
        r_side1[0] <= '{sa: r_sa, sg: r_sg, sn: n_nv[70],
                        am: r_am, gm: r_gm,
                        nm: n_nv[70] ? NUMW'(-n_nv) : NUMW'(n_nv),
                        mr: r_q_mr};
        for (int k = 1; k <= SQRT_N; k++) begin
            r_side1[k] <= r_side1[k-1];
        end
    end

    // square root chain
    logic [REMW-1:0] w_srem  [0:SQRT_N];
    logic [RTW-1:0]  w_sroot [0:SQRT_N];
    logic [RADW-1:0] w_srad  [0:SQRT_N];

    assign w_srem[0]  = '0;
    assign w_sroot[0] = '0;
    assign w_srad[0]  = r_ss;

    for (genvar g = 0; g < SQRT_N; g++) begin : g_sqrt
        rrj_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rem  (w_srem[g]),
            .i_root (w_sroot[g]),
            .i_rad  (w_srad[g]),
            .o_rem  (w_srem[g+1]),
            .o_root (w_sroot[g+1]),
            .o_rad  (w_srad[g+1])
        );
    end

    // divider inputs, residual and degenerate flag
    logic [RTW-1:0]     w_d;
    logic [NUMW-1:0]    w_half;
    logic signed [36:0] n_res;
    logic signed [31:0] n_res_sat;
    t_side1             w_s1;
    t_side2             r_side2 [0:DIV_N-1];

    assign w_d    = w_sroot[SQRT_N];
    assign w_s1   = r_side1[SQRT_N];
    assign w_half = NUMW'(w_d >> 1);
    assign n_res  = $signed({1'b0, w_d}) - $signed({6'b0, w_s1.mr});

    always_comb begin
        if (n_res > 37'sd2147483647) begin
            n_res_sat = 32'sh7fffffff;
        end else if (n_res < -37'sd2147483648) begin
            n_res_sat = 32'sh80000000;
        end else begin
            n_res_sat = n_res[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_side2[0] <= '{sa: w_s1.sa, sg: w_s1.sg, sn: w_s1.sn,
                        deg: (w_d == '0), res: n_res_sat};
        for (int k = 1; k < DIV_N; k++) begin
            r_side2[k] <= r_side2[k-1];
        end
    end

    // three divider chains: alpha/d, gamma/d, heading numerator/d
    logic [NUMW-1:0] w_rem [0:2][0:DIV_N];
    logic [RTW-1:0]  w_den [0:2][0:DIV_N];
    logic [QW-1:0]   w_q   [0:2][0:DIV_N];

    assign w_rem[0][0] = NUMW'({w_s1.am, 16'b0}) + w_half;
    assign w_rem[1][0] = NUMW'({w_s1.gm, 16'b0}) + w_half;
    assign w_rem[2][0] = w_s1.nm + w_half;

    for (genvar u = 0; u < 3; u++) begin : g_div
        assign w_den[u][0] = w_d;
        assign w_q[u][0]   = '0;
        for (genvar g = 0; g < DIV_N; g++) begin : g_cell
            rrj_div_cell u_cell (
                .i_clk  (i_clk),
                .i_step (6'(DIV_N - 1 - g)),
                .i_rem  (w_rem[u][g]),
                .i_den  (w_den[u][g]),
                .i_q    (w_q[u][g]),
                .o_rem  (w_rem[u][g+1]),
                .o_den  (w_den[u][g+1]),
                .o_q    (w_q[u][g+1])
            );
        end
    end

    // sign, saturation and output register
    t_side2             w_s2;
    logic [QW-1:0]      w_qh;
    logic signed [17:0] n_jx, n_jy;
    logic signed [31:0] n_jh;
    logic signed [31:0] r_res, r_jh;
    logic signed [17:0] r_jx, r_jy;
    logic               r_deg;

    assign w_s2 = r_side2[DIV_N-1];
    assign w_qh = w_q[2][DIV_N];

    always_comb begin
        n_jx = w_s2.sa ? -$signed(w_q[0][DIV_N][17:0]) : $signed(w_q[0][DIV_N][17:0]);
        n_jy = w_s2.sg ? -$signed(w_q[1][DIV_N][17:0]) : $signed(w_q[1][DIV_N][17:0]);
        if (w_s2.sn) begin
            n_jh = (w_qh > QW'(32'h8000_0000)) ? 32'sh80000000 : -$signed(w_qh[31:0]);
        end else begin
            n_jh = (w_qh > QW'(32'h7fff_ffff)) ? 32'sh7fffffff : $signed(w_qh[31:0]);
        end
        if (w_s2.deg) begin
            n_jx = '0;
            n_jy = '0;
            n_jh = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= w_s2.res;
        r_jx  <= n_jx;
        r_jy  <= n_jy;
        r_jh  <= n_jh;
        r_deg <= w_s2.deg;
    end

    assign o_valid          = r_vld[LAT];
    assign o_range_residual = r_res;
    assign o_jac_x          = r_jx;
    assign o_jac_y          = r_jy;
    assign o_jac_heading    = r_jh;
    assign o_degenerate     = r_deg;

    // a result always traces back to an earlier request taken on start
    a_valid_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT + 1))
        else $error("result strobe without matching request");

    // degenerate rows carry a zero jacobian
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> (o_jac_x == 0 && o_jac_y == 0 && o_jac_heading == 0))
        else $error("degenerate row with nonzero jacobian");

    // unit direction components stay within one
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_jac_x <= 18'sd65536 && o_jac_x >= -18'sd65536 &&
                     o_jac_y <= 18'sd65536 && o_jac_y >= -18'sd65536))
        else $error("jacobian direction component out of range");

endmodule

>>> design/rrj_cordic_cell.sv
// one rotation-mode cordic step with its output register
// depends on rrj_pkg
module rrj_cordic_cell import rrj_pkg::*; (
    input  logic       i_clk,
    input  logic [4:0] i_step,
    input  t_cs        i_x,
    input  t_cs        i_y,
    input  t_ang       i_z,
    input  logic       i_flip,
    output t_cs        o_x,
    output t_cs        o_y,
    output t_ang       o_z,
    output logic       o_flip
);
    t_cs  r_x, r_y, n_x, n_y, w_xs, w_ys;
    t_ang r_z, n_z;
    logic r_flip;

    // micro-rotation toward zero residual angle
    always_comb begin
        w_xs = i_x >>> i_step;
        w_ys = i_y >>> i_step;
        if (i_z >= 0) begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - f_atan(i_step);
        end else begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + f_atan(i_step);
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_flip <= i_flip;
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_flip = r_flip;
endmodule

>>> design/rrj_sqrt_cell.sv
// one digit of a restoring integer square root, two radicand bits per cell
// depends on rrj_pkg
module rrj_sqrt_cell import rrj_pkg::*; (
    input  logic            i_clk,
    input  logic [REMW-1:0] i_rem,
    input  logic [RTW-1:0]  i_root,
    input  logic [RADW-1:0] i_rad,
    output logic [REMW-1:0] o_rem,
    output logic [RTW-1:0]  o_root,
    output logic [RADW-1:0] o_rad
);
    logic [REMW-1:0] r_rem, n_rem, w_cat, w_trial;
    logic [RTW-1:0]  r_root, n_root;
    logic [RADW-1:0] r_rad;

    // bring in the next bit pair and try a one digit
    always_comb begin
        w_cat   = {i_rem[REMW-3:0], i_rad[RADW-1 -: 2]};
        w_trial = {{(REMW-RTW-2){1'b0}}, i_root, 2'b01};
        if (w_cat >= w_trial) begin
            n_rem  = w_cat - w_trial;
            n_root = {i_root[RTW-2:0], 1'b1};
        end else begin
            n_rem  = w_cat;
            n_root = {i_root[RTW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
        r_rad  <= {i_rad[RADW-3:0], 2'b00};
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;
endmodule

>>> design/rrj_div_cell.sv
// one quotient bit of a restoring divider, shifted divisor compared in place
// depends on rrj_pkg
module rrj_div_cell import rrj_pkg::*; (
    input  logic            i_clk,
    input  logic [5:0]      i_step,
    input  logic [NUMW-1:0] i_rem,
    input  logic [RTW-1:0]  i_den,
    input  logic [QW-1:0]   i_q,
    output logic [NUMW-1:0] o_rem,
    output logic [RTW-1:0]  o_den,
    output logic [QW-1:0]   o_q
);
    logic [NUMW-1:0] r_rem, n_rem, w_trial;
    logic [RTW-1:0]  r_den;
    logic [QW-1:0]   r_q, n_q;

    // subtract divisor scaled to this bit when it fits
    always_comb begin
        w_trial = {{(NUMW-RTW){1'b0}}, i_den} << i_step;
        n_rem   = i_rem;
        n_q     = i_q;
        if (i_rem >= w_trial) begin
            n_rem       = i_rem - w_trial;
            n_q[i_step] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= i_den;
        r_q   <= n_q;
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_q   = r_q;
endmodule
